// ===== rtl/lfm_pkg.sv =====
`timescale 1ns / 1ps

package lfm_pkg;

  localparam int unsigned NUM_COND  = 3;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned FAIL_W    = 8;
  localparam logic [FAIL_W-1:0] FAIL_MAX = 8'd255;

  // mode bit positions
  localparam int unsigned MODE_ENABLE   = 0;
  localparam int unsigned MODE_AUTO_REC = 1;
  localparam int unsigned MODE_OVERRIDE = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE        = 4'd0,
    REG_SIG_THRESH  = 4'd1,
    REG_SIG_HOLD    = 4'd2,
    REG_LAT_THRESH  = 4'd3,
    REG_LAT_HOLD    = 4'd4,
    REG_LOSS_THRESH = 4'd5,
    REG_LOSS_HOLD   = 4'd6,
    REG_REC_DELAY   = 4'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_SIGNAL  = 2'd1,
    CAUSE_LATENCY = 2'd2,
    CAUSE_LOSS    = 2'd3
  } cause_e;

  typedef enum logic [1:0] {
    ACT_NONE         = 2'd0,
    ACT_SWITCH       = 2'd1,
    ACT_BITRATE      = 2'd2,
    ACT_RESET_FILTER = 2'd3
  } action_e;

  typedef struct packed {
    logic [2:0]  mode_bits;
    logic [9:0]  low_signal_threshold;
    logic [15:0] low_signal_hold_ms;
    logic [15:0] latency_threshold;
    logic [15:0] latency_hold_ms;
    logic [15:0] loss_threshold;
    logic [15:0] loss_hold_ms;
    logic [15:0] rec_delay_ms;
  } lfm_cfg_t;

  typedef struct packed {
    logic                fallback_flag;
    cause_e              cause;
    logic [FAIL_W-1:0]   fail_counter;
    action_e             prev_action;
    logic [NUM_COND-1:0] cond_pending;
  } lfm_ctl_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [9:0]  rssi_tenths;
    logic [15:0] latency_tenths_ms;
    logic [15:0] loss_fraction;
  } lfm_item_t;

  typedef struct packed {
    logic              fallback_on;
    cause_e            trigger_cause;
    action_e           action_now;
    action_e           last_action_code;
    logic [FAIL_W-1:0] failure_count;
    logic              switch_advised;
    logic              recovered;
    logic [31:0]       elapsed_ms;
  } lfm_result_t;

endpackage

// ===== rtl/lfm_if.sv =====
`timescale 1ns / 1ps

interface lfm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [9:0]  rssi_tenths;
  logic [15:0] latency_tenths_ms;
  logic [15:0] loss_fraction;

  modport source (output valid, now_ms, rssi_tenths, latency_tenths_ms, loss_fraction,
                  input ready);
  modport sink   (input valid, now_ms, rssi_tenths, latency_tenths_ms, loss_fraction,
                  output ready);
endinterface

interface lfm_out_if
  import lfm_pkg::*;
;
  logic        valid;
  logic        ready;
  logic        fallback_on;
  cause_e      trigger_cause;
  action_e     action_now;
  action_e     last_action_code;
  logic [7:0]  failure_count;
  logic        switch_advised;
  logic        recovered;
  logic [31:0] elapsed_ms;

  modport source (output valid, fallback_on, trigger_cause, action_now, last_action_code,
                         failure_count, switch_advised, recovered, elapsed_ms,
                  input ready);
  modport sink   (input valid, fallback_on, trigger_cause, action_now, last_action_code,
                        failure_count, switch_advised, recovered, elapsed_ms,
                  output ready);
endinterface

// ===== rtl/lfm_step.sv =====
`timescale 1ns / 1ps

module lfm_step
  import lfm_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  lfm_cfg_t                            cfg_i,
  input  lfm_item_t                           item_i,
  input  lfm_ctl_t                            ctl_i,
  input  logic [NUM_COND-1:0][TIME_BITS-1:0]  cond_stamp_i,
  input  logic [TIME_BITS-1:0]                start_stamp_i,
  output lfm_ctl_t                            ctl_o,
  output logic [NUM_COND-1:0][TIME_BITS-1:0]  cond_stamp_o,
  output logic [TIME_BITS-1:0]                start_stamp_o,
  output lfm_result_t                         result_o
);

  logic [TIME_BITS+31:0]               now_ext;
  logic [TIME_BITS-1:0]                now_t;
  logic [NUM_COND-1:0]                 met;
  logic [NUM_COND-1:0]                 qual;
  logic [NUM_COND-1:0][15:0]           hold;
  logic [NUM_COND-1:0][TIME_BITS+15:0] hold_ext;
  logic [NUM_COND-1:0][TIME_BITS-1:0]  stamp_n;
  logic [TIME_BITS+15:0]               rec_ext;
  logic [TIME_BITS-1:0]                start_diff;
  logic [TIME_BITS+31:0]               elapsed_ext;
  logic                                any_q;
  cause_e                              cause_n;
  action_e                             act;
  logic                                rec;

  // timestamps are taken modulo 2^TIME_BITS
  assign now_ext = {{TIME_BITS{1'b0}}, item_i.now_ms};
  assign now_t   = now_ext[TIME_BITS-1:0];

  assign met[0] = item_i.rssi_tenths < cfg_i.low_signal_threshold;
  assign met[1] = item_i.latency_tenths_ms > cfg_i.latency_threshold;
  assign met[2] = item_i.loss_fraction > cfg_i.loss_threshold;
  assign hold[0] = cfg_i.low_signal_hold_ms;
  assign hold[1] = cfg_i.latency_hold_ms;
  assign hold[2] = cfg_i.loss_hold_ms;

  always_comb begin
    cause_n = ctl_i.cause;
    for (int i = 0; i < NUM_COND; i++) begin
      hold_ext[i] = {{TIME_BITS{1'b0}}, hold[i]};
      stamp_n[i]  = (met[i] && !ctl_i.cond_pending[i]) ? now_t : cond_stamp_i[i];
      qual[i]     = met[i] && ((now_t - stamp_n[i]) >= hold_ext[i][TIME_BITS-1:0]);
      // later conditions in the fixed order take precedence
      if (qual[i]) cause_n = cause_e'(2'(i + 1));
    end
  end

  assign any_q      = |qual;
  assign rec_ext    = {{TIME_BITS{1'b0}}, cfg_i.rec_delay_ms};
  assign start_diff = now_t - start_stamp_i;

  always_comb begin
    ctl_o         = ctl_i;
    cond_stamp_o  = cond_stamp_i;
    start_stamp_o = start_stamp_i;
    act           = ACT_NONE;
    rec           = 1'b0;
    if (cfg_i.mode_bits[MODE_ENABLE]) begin
      ctl_o.cond_pending = met;
      ctl_o.cause        = cause_n;
      cond_stamp_o       = stamp_n;
      if (any_q && !ctl_i.fallback_flag) begin
        ctl_o.fallback_flag = 1'b1;
        start_stamp_o       = now_t;
        if (ctl_i.fail_counter != FAIL_MAX) ctl_o.fail_counter = ctl_i.fail_counter + 1'b1;
        if (!cfg_i.mode_bits[MODE_OVERRIDE]) begin
          act               = action_e'(cause_n);
          ctl_o.prev_action = action_e'(cause_n);
        end
      end else if (!any_q && ctl_i.fallback_flag && cfg_i.mode_bits[MODE_AUTO_REC] &&
                   (start_diff >= rec_ext[TIME_BITS-1:0])) begin
        ctl_o.fallback_flag = 1'b0;
        ctl_o.cause         = CAUSE_NONE;
        ctl_o.fail_counter  = '0;
        ctl_o.cond_pending  = '0;
        rec                 = 1'b1;
      end
    end
  end

  assign elapsed_ext = {32'd0, now_t - start_stamp_o};

  always_comb begin
    result_o.fallback_on      = ctl_o.fallback_flag;
    result_o.trigger_cause    = ctl_o.cause;
    result_o.action_now       = act;
    result_o.last_action_code = ctl_o.prev_action;
    result_o.failure_count    = ctl_o.fail_counter;
    result_o.switch_advised   = ctl_o.fallback_flag && (ctl_o.prev_action == ACT_SWITCH);
    result_o.recovered        = rec;
    result_o.elapsed_ms       = ctl_o.fallback_flag ? elapsed_ext[31:0] : 32'd0;
  end

endmodule

// ===== rtl/link_fallback_monitor.sv =====
`timescale 1ns / 1ps

// link fallback monitor
// in_i carries one telemetry word per handshake: timestamp, rssi, latency and loss.
// out_o returns exactly one status word for each input word, in order.
// cfg_we_i / cfg_idx_i / cfg_data_i write the threshold, hold and mode registers;
// indexes past the recovery delay register are ignored. write only while idle.
// pipeline: an input register, then combinational compare and timer logic that
// updates the supervisor state and loads the result register.
// a word passes from the input register to the result register, then to out_o.
// throughput: one word per cycle while out_o does not stall, set by the state update loop.
// a stalled receiver holds the result register; the input register still takes
// one word while the result waits, then in_i.ready drops until out_o drains.
// reset clears all supervisor state and timers, loads the register defaults
// (monitor and auto recovery on) and empties both pipeline registers.
module link_fallback_monitor
  import lfm_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lfm_in_if.sink                in_i,
  lfm_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  lfm_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:        cfg_d.mode_bits            = cfg_data_i[2:0];
        REG_SIG_THRESH:  cfg_d.low_signal_threshold = cfg_data_i[9:0];
        REG_SIG_HOLD:    cfg_d.low_signal_hold_ms   = cfg_data_i;
        REG_LAT_THRESH:  cfg_d.latency_threshold    = cfg_data_i;
        REG_LAT_HOLD:    cfg_d.latency_hold_ms      = cfg_data_i;
        REG_LOSS_THRESH: cfg_d.loss_threshold       = cfg_data_i;
        REG_LOSS_HOLD:   cfg_d.loss_hold_ms         = cfg_data_i;
        REG_REC_DELAY:   cfg_d.rec_delay_ms         = cfg_data_i;
        default:         cfg_d = cfg_q; // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_bits            <= 3'd3;
      cfg_q.low_signal_threshold <= 10'd200;
      cfg_q.low_signal_hold_ms   <= 16'd2000;
      cfg_q.latency_threshold    <= 16'd1000;
      cfg_q.latency_hold_ms      <= 16'd1000;
      cfg_q.loss_threshold       <= 16'd6554;
      cfg_q.loss_hold_ms         <= 16'd1500;
      cfg_q.rec_delay_ms         <= 16'd5000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // handshake and pipeline control
  logic        in_valid_q, in_valid_d;
  logic        out_valid_q, out_valid_d;
  logic        advance;   // result register free or draining this cycle
  logic        step_en;   // word in the input register is processed now
  logic        in_fire;
  lfm_item_t   item_q;
  lfm_result_t res_q, res_d;

  assign advance     = !out_valid_q || out_o.ready;
  assign step_en     = in_valid_q && advance;
  assign in_i.ready  = !in_valid_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;
  assign in_valid_d  = in_fire || (in_valid_q && !advance);
  assign out_valid_d = step_en || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register, payload only
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.now_ms            <= in_i.now_ms;
      item_q.rssi_tenths       <= in_i.rssi_tenths;
      item_q.latency_tenths_ms <= in_i.latency_tenths_ms;
      item_q.loss_fraction     <= in_i.loss_fraction;
    end
  end

  // supervisor state
  lfm_ctl_t                           ctl_q, ctl_d;
  logic [NUM_COND-1:0][TIME_BITS-1:0] cond_stamp_q, cond_stamp_d;
  logic [TIME_BITS-1:0]               start_stamp_q, start_stamp_d;

  lfm_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .cfg_i         (cfg_q),
    .item_i        (item_q),
    .ctl_i         (ctl_q),
    .cond_stamp_i  (cond_stamp_q),
    .start_stamp_i (start_stamp_q),
    .ctl_o         (ctl_d),
    .cond_stamp_o  (cond_stamp_d),
    .start_stamp_o (start_stamp_d),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.fallback_flag <= 1'b0;
      ctl_q.cause         <= CAUSE_NONE;
      ctl_q.fail_counter  <= '0;
      ctl_q.prev_action   <= ACT_NONE;
      ctl_q.cond_pending  <= '0;
      cond_stamp_q        <= '0;
      start_stamp_q       <= '0;
    end else if (step_en) begin
      ctl_q         <= ctl_d;
      cond_stamp_q  <= cond_stamp_d;
      start_stamp_q <= start_stamp_d;
    end
  end

  // result register, held while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (step_en) res_q <= res_d;
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.fallback_on      = res_q.fallback_on;
  assign out_o.trigger_cause    = res_q.trigger_cause;
  assign out_o.action_now       = res_q.action_now;
  assign out_o.last_action_code = res_q.last_action_code;
  assign out_o.failure_count    = res_q.failure_count;
  assign out_o.switch_advised   = res_q.switch_advised;
  assign out_o.recovered        = res_q.recovered;
  assign out_o.elapsed_ms       = res_q.elapsed_ms;

  // supervisor state only moves when a word is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en |=> $stable(ctl_q) && $stable(start_stamp_q))
    else $error("supervisor state changed without a word");

  // a recovery leaves fallback off with cause and counter cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.recovered |->
      !res_q.fallback_on && res_q.trigger_cause == CAUSE_NONE && res_q.failure_count == '0)
    else $error("recovery left fallback state behind");

  // an issued action is the new last action and comes with fallback on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.action_now != ACT_NONE |->
      res_q.fallback_on && res_q.last_action_code == res_q.action_now &&
      res_q.failure_count != '0)
    else $error("action issued without activation");

  // the result register matches the state it was computed with
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |=> res_q.fallback_on == ctl_q.fallback_flag &&
                res_q.failure_count == ctl_q.fail_counter)
    else $error("result out of step with state");

  // elapsed time is zero while inactive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.fallback_on |-> res_q.elapsed_ms == 32'd0)
    else $error("elapsed time reported while inactive");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import lfm_pkg::*;

  // per item wait drawn by either side
  localparam int unsigned WAIT_MAX = 17;
  // slowest correct item: source gap + sink stall + the pass through both pipeline registers
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASES = 8;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] IDX_PAST_END = 4'd8;
  localparam logic [CFG_IDX_W-1:0] IDX_LAST     = 4'hf;

  // mode register bits
  localparam logic [CFG_DATA_W-1:0] M_RUN   = CFG_DATA_W'(1 << MODE_ENABLE);
  localparam logic [CFG_DATA_W-1:0] M_AUTO  = CFG_DATA_W'(1 << MODE_AUTO_REC);
  localparam logic [CFG_DATA_W-1:0] M_QUIET = CFG_DATA_W'(1 << MODE_OVERRIDE);

  // what the sender knows about each word it puts on the channel
  typedef struct packed {
    bit          typed;
    lfm_result_t want;
  } sent_note_t;

  // one line of the directed script: either a register write or a telemetry word
  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    lfm_item_t             word;
    bit                    typed;
    lfm_result_t           want;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lfm_in_if  in_if ();
  lfm_out_if out_if ();

  link_fallback_monitor u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mirror of the supervisor: registers as written through the port
  logic [2:0]  mon_mode;
  logic [9:0]  sig_thr;
  logic [15:0] sig_hold;
  logic [15:0] lat_thr;
  logic [15:0] lat_hold;
  logic [15:0] loss_thr;
  logic [15:0] loss_hold;
  logic [15:0] rec_delay;

  // mirror of the supervisor state
  logic                fb_on;
  cause_e              fb_cause;
  logic [31:0]         fb_start;
  logic [FAIL_W-1:0]   fb_count;
  action_e             fb_last;
  logic [NUM_COND-1:0] cond_armed;
  logic [31:0]         cond_since [NUM_COND];

  lfm_result_t status_q [$];   // status words still owed by the block, oldest first
  sent_note_t  note_q [$];     // words handed to the channel, not yet taken
  script_row_t script [$];

  int errors = 0;
  int idle_cycles = 0;
  int src_quiet = 0;

  // wait before the next word: random, with stretches of back-to-back traffic
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(10, 40);
    return $urandom_range(0, WAIT_MAX);
  endfunction

  // advance the mirrored state by one telemetry word and return the status it earns
  function automatic lfm_result_t supervise_word(lfm_item_t w);
    lfm_result_t         r;
    logic [NUM_COND-1:0] met;
    logic [15:0]         hold_ms [NUM_COND];
    bit                  any;
    r = '0;
    if (mon_mode[MODE_ENABLE]) begin
      met[0] = w.rssi_tenths < sig_thr;
      met[1] = w.latency_tenths_ms > lat_thr;
      met[2] = w.loss_fraction > loss_thr;
      hold_ms[0] = sig_hold;
      hold_ms[1] = lat_hold;
      hold_ms[2] = loss_hold;
      any = 1'b0;
      // fixed order: signal, latency, loss; the last one qualified names the cause
      for (int c = 0; c < NUM_COND; c++) begin
        if (met[c]) begin
          if (!cond_armed[c]) begin
            cond_armed[c] = 1'b1;
            cond_since[c] = w.now_ms;
          end
          if (32'(w.now_ms - cond_since[c]) >= 32'(hold_ms[c])) begin
            fb_cause = cause_e'(2'(c + 1));
            any = 1'b1;
          end
        end else begin
          cond_armed[c] = 1'b0;
        end
      end
      if (any && !fb_on) begin
        fb_on = 1'b1;
        fb_start = w.now_ms;
        if (fb_count != FAIL_MAX) fb_count++;
        // each cause has the action of the same code
        if (!mon_mode[MODE_OVERRIDE]) begin
          r.action_now = action_e'(fb_cause);
          fb_last = action_e'(fb_cause);
        end
      end else if (!any && fb_on && mon_mode[MODE_AUTO_REC]) begin
        if (32'(w.now_ms - fb_start) >= 32'(rec_delay)) begin
          fb_on = 1'b0;
          fb_cause = CAUSE_NONE;
          fb_count = '0;
          cond_armed = '0;
          r.recovered = 1'b1;
        end
      end
    end
    r.fallback_on = fb_on;
    r.trigger_cause = fb_cause;
    r.last_action_code = fb_last;
    r.failure_count = fb_count;
    r.switch_advised = fb_on && (fb_last == ACT_SWITCH);
    r.elapsed_ms = fb_on ? 32'(w.now_ms - fb_start) : 32'd0;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_status(lfm_result_t want, lfm_result_t got);
    check_field("fallback_on", want.fallback_on, got.fallback_on);
    check_field("trigger_cause", want.trigger_cause, got.trigger_cause);
    check_field("action_now", want.action_now, got.action_now);
    check_field("last_action_code", want.last_action_code, got.last_action_code);
    check_field("failure_count", want.failure_count, got.failure_count);
    check_field("switch_advised", want.switch_advised, got.switch_advised);
    check_field("recovered", want.recovered, got.recovered);
    check_field("elapsed_ms", want.elapsed_ms, got.elapsed_ms);
  endfunction

  function automatic void add_word(logic [31:0] now, logic [9:0] rssi, logic [15:0] lat,
                                   logic [15:0] loss, bit typed = 1'b0,
                                   lfm_result_t want = '0);
    script_row_t row;
    row = '0;
    row.word.now_ms = now;
    row.word.rssi_tenths = rssi;
    row.word.latency_tenths_ms = lat;
    row.word.loss_fraction = loss;
    row.typed = typed;
    row.want = want;
    script.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    script_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    script.push_back(row);
  endfunction

  // put one word on the input channel and hold it until taken; valid stays up
  // afterwards so that a word with no gap follows straight on
  task automatic send_word(lfm_item_t w, bit typed, lfm_result_t want);
    int         gap;
    sent_note_t note;
    gap = draw_wait(src_quiet);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    note.typed = typed;
    note.want = want;
    note_q.push_back(note);
    in_if.valid <= 1'b1;
    in_if.now_ms <= w.now_ms;
    in_if.rssi_tenths <= w.rssi_tenths;
    in_if.latency_tenths_ms <= w.latency_tenths_ms;
    in_if.loss_fraction <= w.loss_fraction;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write of a group
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // stop sending and wait for every owed status word, then let the pipe settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (status_q.size() != 0 || note_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // scoreboard: register writes, status words out, telemetry words in
  always @(posedge clk) begin
    lfm_result_t got;
    lfm_item_t   w;
    sent_note_t  note;
    if (!rst_n) begin
      mon_mode = M_RUN[2:0] | M_AUTO[2:0];
      sig_thr = 10'd200;
      sig_hold = 16'd2000;
      lat_thr = 16'd1000;
      lat_hold = 16'd1000;
      loss_thr = 16'd6554;
      loss_hold = 16'd1500;
      rec_delay = 16'd5000;
      fb_on = 1'b0;
      fb_cause = CAUSE_NONE;
      fb_start = '0;
      fb_count = '0;
      fb_last = ACT_NONE;
      cond_armed = '0;
      for (int c = 0; c < NUM_COND; c++) cond_since[c] = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_MODE:        mon_mode = cfg_data[2:0];
          REG_SIG_THRESH:  sig_thr = cfg_data[9:0];
          REG_SIG_HOLD:    sig_hold = cfg_data;
          REG_LAT_THRESH:  lat_thr = cfg_data;
          REG_LAT_HOLD:    lat_hold = cfg_data;
          REG_LOSS_THRESH: loss_thr = cfg_data;
          REG_LOSS_HOLD:   loss_hold = cfg_data;
          REG_REC_DELAY:   rec_delay = cfg_data;
          default: ;       // no register behind the index
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        got.fallback_on = out_if.fallback_on;
        got.trigger_cause = out_if.trigger_cause;
        got.action_now = out_if.action_now;
        got.last_action_code = out_if.last_action_code;
        got.failure_count = out_if.failure_count;
        got.switch_advised = out_if.switch_advised;
        got.recovered = out_if.recovered;
        got.elapsed_ms = out_if.elapsed_ms;
        if (status_q.size() == 0) begin
          $display("%0t: status word expected none, got %h", $time, got);
          errors++;
        end else begin
          check_status(status_q.pop_front(), got);
        end
      end
      if (in_if.valid && in_if.ready) begin
        w.now_ms = in_if.now_ms;
        w.rssi_tenths = in_if.rssi_tenths;
        w.latency_tenths_ms = in_if.latency_tenths_ms;
        w.loss_fraction = in_if.loss_fraction;
        note = note_q.pop_front();
        // the mirror always advances; a typed-in row replaces its prediction
        got = supervise_word(w);
        status_q.push_back(note.typed ? note.want : got);
      end
    end
  end

  // watchdog: cycles in which nothing moves on any port
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls per status word, with calm stretches
  initial begin
    int sink_quiet;
    int stall;
    sink_quiet = 0;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait(sink_quiet);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  initial begin
    script_row_t row;
    lfm_result_t lat_first;
    lfm_item_t   w;
    bit          cfg_open;
    bit          lo;
    bit          hi;
    bit          bad [NUM_COND];
    int          mode;
    int          g_sthr;
    int          g_lthr;
    int          g_pthr;
    int          pick;
    int          n_words;
    logic [31:0] now;

    rst_n = 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.now_ms <= '0;
    in_if.rssi_tenths <= '0;
    in_if.latency_tenths_ms <= '0;
    in_if.loss_fraction <= '0;

    // latency is first to qualify with the default hold times
    lat_first = '0;
    lat_first.fallback_on = 1'b1;
    lat_first.trigger_cause = CAUSE_LATENCY;
    lat_first.action_now = ACT_BITRATE;
    lat_first.last_action_code = ACT_BITRATE;
    lat_first.failure_count = 8'd1;

    // directed script, default registers after reset
    add_word(32'd0, 10'd1000, 16'd0, 16'd0, 1'b1, '0);              // healthy link
    add_word(32'd100, 10'd0, 16'hffff, 16'hffff, 1'b1, '0);         // all bad, timers armed
    add_word(32'd1100, 10'd0, 16'hffff, 16'hffff, 1'b1, lat_first);
    add_word(32'd1600, 10'd0, 16'hffff, 16'hffff);                  // loss takes over the cause
    add_word(32'd2100, 10'd0, 16'hffff, 16'hffff);                  // all three qualified
    add_word(32'd3000, 10'd1000, 16'd0, 16'd0);                     // too early to recover
    add_word(32'd6100, 10'd1000, 16'd0, 16'd0);                     // recovery delay reached
    add_word(32'd6200, 10'd0, 16'd0, 16'd0);
    add_word(32'd8200, 10'd199, 16'd1000, 16'd6554);                // signal only, switch advised
    add_cfg(REG_MODE, '0);                                           // monitor off
    add_word(32'd9000, 10'd1000, 16'd0, 16'd0);
    add_cfg(REG_MODE, M_RUN | M_AUTO | M_QUIET);                     // actions suppressed
    add_word(32'd20000, 10'd1000, 16'd0, 16'd0);
    add_cfg(REG_SIG_HOLD, '0);
    add_cfg(REG_LAT_HOLD, '0);
    add_cfg(REG_LOSS_HOLD, '0);
    add_word(32'd20001, 10'd200, 16'd1001, 16'd6554);               // zero hold, no action
    add_cfg(REG_MODE, M_RUN);                                        // no auto recovery
    add_word(32'hffff_ffff, 10'd1000, 16'd0, 16'd0);
    add_word(32'h0000_0010, 10'd1000, 16'd0, 16'd0);                // elapsed across the wrap
    add_cfg(IDX_PAST_END, 16'hffff);
    add_cfg(IDX_LAST, 16'h0000);
    add_word(32'h0000_0020, 10'd1000, 16'd0, 16'd0);                // writes above had no effect
    add_cfg(REG_MODE, M_RUN | M_AUTO);
    add_cfg(REG_REC_DELAY, '0);
    add_word(32'h0000_0021, 10'd1000, 16'd0, 16'd0);                // immediate recovery

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    cfg_open = 1'b0;
    foreach (script[i]) begin
      row = script[i];
      if (row.is_cfg) begin
        if (!cfg_open) begin
          drain();
          cfg_open = 1'b1;
        end
        write_reg(row.idx, row.data);
      end else begin
        if (cfg_open) begin
          cfg_we <= 1'b0;
          cfg_open = 1'b0;
        end
        send_word(row.word, row.typed, row.want);
      end
    end

    // random phases: fresh registers each time, the first all minimum, one all maximum
    for (int p = 0; p < PHASES; p++) begin
      lo = (p == 0);
      hi = (p == 4);
      mode = (p * 5 + 3) % 8;
      g_sthr = lo ? 0 : hi ? 1000 : $urandom_range(1, 1000);
      g_lthr = lo ? 0 : hi ? 65535 : $urandom_range(0, 65534);
      g_pthr = lo ? 0 : hi ? 65535 : $urandom_range(0, 65534);
      drain();
      write_reg(REG_MODE, CFG_DATA_W'(mode));
      write_reg(REG_SIG_THRESH, CFG_DATA_W'(g_sthr));
      write_reg(REG_SIG_HOLD, lo ? 16'd0 : hi ? 16'hffff : 16'($urandom_range(0, 3000)));
      write_reg(REG_LAT_THRESH, CFG_DATA_W'(g_lthr));
      write_reg(REG_LAT_HOLD, lo ? 16'd0 : hi ? 16'hffff : 16'($urandom_range(0, 3000)));
      write_reg(REG_LOSS_THRESH, CFG_DATA_W'(g_pthr));
      write_reg(REG_LOSS_HOLD, lo ? 16'd0 : hi ? 16'hffff : 16'($urandom_range(0, 3000)));
      write_reg(REG_REC_DELAY, lo ? 16'd0 : hi ? 16'hffff : 16'($urandom_range(0, 8000)));
      cfg_we <= 1'b0;

      now = $urandom;
      for (int c = 0; c < NUM_COND; c++) bad[c] = 1'b0;
      // a disabled monitor just reports, so spend few words there
      n_words = ((mode >> MODE_ENABLE) & 1) ? 130 : 25;
      repeat (n_words) begin
        // conditions come and go in episodes so that hold times can be met
        for (int c = 0; c < NUM_COND; c++) begin
          if ($urandom_range(0, 7) == 0) bad[c] = !bad[c];
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) now += $urandom_range(0, 400);
        else if (pick < 90) now += $urandom_range(0, 3000);
        else if (pick < 98) now += $urandom_range(0, 70000);
        else now += $urandom;
        w.now_ms = now;
        if ($urandom_range(0, 9) == 0) begin
          // noise word
          w.rssi_tenths = 10'($urandom_range(0, 1000));
          w.latency_tenths_ms = 16'($urandom_range(0, 65535));
          w.loss_fraction = 16'($urandom_range(0, 65535));
        end else begin
          w.rssi_tenths = (bad[0] && g_sthr > 0) ? 10'($urandom_range(0, g_sthr - 1))
                                                 : 10'($urandom_range(g_sthr, 1000));
          w.latency_tenths_ms = (bad[1] && g_lthr < 65535)
                                ? 16'($urandom_range(g_lthr + 1, 65535))
                                : 16'($urandom_range(0, g_lthr));
          w.loss_fraction = (bad[2] && g_pthr < 65535)
                            ? 16'($urandom_range(g_pthr + 1, 65535))
                            : 16'($urandom_range(0, g_pthr));
        end
        send_word(w, 1'b0, '0);
      end
    end

    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
